// ===== design/gprs_pkg.sv =====
package gprs_pkg;

    localparam int SUBPIXEL_BITS  = 6;
    localparam int TRIG_FRAC_BITS = 15;

    localparam int ORIGIN_X = 320;
    localparam int ORIGIN_Y = 225;

    localparam int PPEM_W = 11;
    localparam int EM_W   = 15;
    localparam int ANG_W  = 10;
    localparam int EXT_W  = 16;
    localparam int PT_W   = 16;
    localparam int FLAG_W = 8;
    localparam int OUT_W  = 32;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_PPEM   = 3'd0;
    localparam logic [IDX_W-1:0] REG_EM     = 3'd1;
    localparam logic [IDX_W-1:0] REG_ANGLE  = 3'd2;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd3;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd4;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // half extent divider
    localparam int HN_W = EXT_W + PPEM_W + 1;
    localparam int HD_W = EM_W + 1;

    localparam int MP_W = PT_W + PPEM_W + 1;
    localparam int D_W  = 30;
    localparam int TQ_W = TRIG_FRAC_BITS + 1;
    localparam int T_W  = TRIG_FRAC_BITS + 2;
    localparam int P_W  = D_W + T_W;
    localparam int A_W  = P_W + 1;
    localparam int SH   = TRIG_FRAC_BITS - SUBPIXEL_BITS;
    localparam int M_W  = A_W - SH;
    localparam int S_W  = M_W + 2;

    localparam int QI_W     = ANG_W - 2;
    localparam int QN       = 1 << QI_W;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    function automatic longint to_trig(input longint q30);
        longint q;
        q = q30;
        if (q < 0)
            q = 0;
        if (q > (64'sd1 <<< 30))
            q = 64'sd1 <<< 30;
        return (q + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    endfunction

    // floor division by shift and subtract, table build only
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q, rem;
        int i;
        q   = 64'd0;
        rem = 64'd0;
        for (i = 63; i >= 0; i--)
        begin
            rem = (rem << 1) | ((n >> i) & 64'd1);
            if (rem >= d)
            begin
                rem = rem - d;
                q   = q | (64'd1 << i);
            end
        end
        return q;
    endfunction

    // quarter-turn cos or sin, Taylor series in Q30, rounded to TRIG_FRAC_BITS
    function automatic logic [QN*TQ_W-1:0] quarter_table(input logic want_sin);
        logic [QN*TQ_W-1:0] tab;
        longint unsigned x, x2, ct, st, dc, ds;
        longint csum, ssum;
        int r, k;
        tab = '0;
        for (r = 0; r < QN; r++)
        begin
            x    = (longint'(r) * PI_Q30) >> (ANG_W - 1);
            x2   = (x * x) >> 30;
            csum = 64'sd1 <<< 30;
            ssum = longint'(x);
            ct   = 64'd1 << 30;
            st   = x;
            for (k = 1; k <= 12; k++)
            begin
                dc = longint'(2 * k - 1) * longint'(2 * k);
                ds = longint'(2 * k) * longint'(2 * k + 1);
                ct = udiv64((ct * x2) >> 30, dc);
                st = udiv64((st * x2) >> 30, ds);
                if ((k & 1) == 1)
                begin
                    csum = csum - longint'(ct);
                    ssum = ssum - longint'(st);
                end
                else
                begin
                    csum = csum + longint'(ct);
                    ssum = ssum + longint'(st);
                end
            end
            tab[r*TQ_W +: TQ_W] = TQ_W'(to_trig(want_sin ? ssum : csum));
        end
        return tab;
    endfunction

    localparam logic [QN*TQ_W-1:0] COS_TAB = quarter_table(1'b0);
    localparam logic [QN*TQ_W-1:0] SIN_TAB = quarter_table(1'b1);

endpackage

// ===== design/glyph_point_rotate_scale.sv =====
// Outline point to screen position transform.
// Input channel: point_valid / point_stall with point_x, point_y (signed font
// units) and point_flags. Output channel: screen_valid / screen_stall with
// screen_x, screen_y (signed, 1/64 pixel, saturated) and on_curve.
// A word moves when valid is high and stall is low at a rising clk edge.
// Configuration: cfg_write_en, cfg_index and cfg_data write one register per
// cycle; write only while no word is in flight.
// Throughput: one word per cycle while the output is not stalled. There are
// 74 register stages in all: the input stage, two bit-serial divider
// pipelines (28 stages for the rounded half extents, a magnitude stage and
// 39 stages for the final divide by the em size), four multiply and add
// stages and the output stage.
// The whole pipeline moves as one; a stall on the output holds every stage
// and raises point_stall in the same cycle, nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the register
// defaults: 449 pixels per em, 2048 units per em, angle 0, extents 0.
module glyph_point_rotate_scale
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [gprs_pkg::IDX_W-1:0]         cfg_index,
    input  logic [gprs_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               point_valid,
    output logic                               point_stall,
    input  logic signed [gprs_pkg::PT_W-1:0]   point_x,
    input  logic signed [gprs_pkg::PT_W-1:0]   point_y,
    input  logic [gprs_pkg::FLAG_W-1:0]        point_flags,
    output logic                               screen_valid,
    input  logic                               screen_stall,
    output logic signed [gprs_pkg::OUT_W-1:0]  screen_x,
    output logic signed [gprs_pkg::OUT_W-1:0]  screen_y,
    output logic                               on_curve
);

    localparam int HN_W = gprs_pkg::HN_W;
    localparam int HD_W = gprs_pkg::HD_W;
    localparam int EM_W = gprs_pkg::EM_W;
    localparam int PT_W = gprs_pkg::PT_W;
    localparam int MP_W = gprs_pkg::MP_W;
    localparam int D_W  = gprs_pkg::D_W;
    localparam int T_W  = gprs_pkg::T_W;
    localparam int TQ_W = gprs_pkg::TQ_W;
    localparam int P_W  = gprs_pkg::P_W;
    localparam int A_W  = gprs_pkg::A_W;
    localparam int SH   = gprs_pkg::SH;
    localparam int M_W  = gprs_pkg::M_W;
    localparam int S_W  = gprs_pkg::S_W;
    localparam int OUT_W = gprs_pkg::OUT_W;

    localparam logic signed [S_W-1:0] CX_FIX =
        S_W'(gprs_pkg::ORIGIN_X * (1 << gprs_pkg::SUBPIXEL_BITS));
    localparam logic signed [S_W-1:0] CY_FIX =
        S_W'(gprs_pkg::ORIGIN_Y * (1 << gprs_pkg::SUBPIXEL_BITS));
    localparam logic signed [S_W-1:0] SAT_MAX = S_W'(64'sd2147483647);
    localparam logic signed [S_W-1:0] SAT_MIN = S_W'(-64'sd2147483648);

    // configuration
    logic [gprs_pkg::PPEM_W-1:0] ppem_reg;
    logic [EM_W-1:0]             em_reg;
    logic [gprs_pkg::ANG_W-1:0]  angle_reg;
    logic [gprs_pkg::EXT_W-1:0]  width_reg;
    logic [gprs_pkg::EXT_W-1:0]  height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppem_reg   <= gprs_pkg::PPEM_W'(449);
            em_reg     <= EM_W'(2048);
            angle_reg  <= '0;
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                gprs_pkg::REG_PPEM:   ppem_reg   <= cfg_data[gprs_pkg::PPEM_W-1:0];
                gprs_pkg::REG_EM:     em_reg     <= cfg_data[EM_W-1:0];
                gprs_pkg::REG_ANGLE:  angle_reg  <= cfg_data[gprs_pkg::ANG_W-1:0];
                gprs_pkg::REG_WIDTH:  width_reg  <= cfg_data[gprs_pkg::EXT_W-1:0];
                gprs_pkg::REG_HEIGHT: height_reg <= cfg_data[gprs_pkg::EXT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [EM_W-1:0] em_eff;
    logic [HD_W-1:0] em_twice;
    assign em_eff   = (em_reg == '0) ? EM_W'(1) : em_reg;
    assign em_twice = {em_eff, 1'b0};

    // cos / sin of the current angle
    logic [gprs_pkg::QI_W-1:0] trig_idx;
    logic [1:0]                trig_quad;
    logic signed [T_W-1:0]     cq, sq, c_next, s_next;
    logic signed [T_W-1:0]     c_reg, s_reg;

    assign trig_idx  = angle_reg[gprs_pkg::QI_W-1:0];
    assign trig_quad = angle_reg[gprs_pkg::ANG_W-1 -: 2];
    assign cq = $signed({1'b0, gprs_pkg::COS_TAB[trig_idx*TQ_W +: TQ_W]});
    assign sq = $signed({1'b0, gprs_pkg::SIN_TAB[trig_idx*TQ_W +: TQ_W]});

    always_comb
    begin
        case (trig_quad)
            gprs_pkg::QUAD_0:
            begin
                c_next = cq;
                s_next = sq;
            end
            gprs_pkg::QUAD_1:
            begin
                c_next = -sq;
                s_next = cq;
            end
            gprs_pkg::QUAD_2:
            begin
                c_next = -cq;
                s_next = -sq;
            end
            default:
            begin
                c_next = sq;
                s_next = -cq;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        s_reg <= s_next;
    end

    logic en;
    assign en          = !screen_valid || !screen_stall;
    assign point_stall = !en;

    // stage 0 and half extent divider, index 0 is the input stage
    logic                   v1_reg  [HN_W+1];
    logic signed [PT_W-1:0] px1_reg [HN_W+1];
    logic signed [PT_W-1:0] py1_reg [HN_W+1];
    logic                   oc1_reg [HN_W+1];
    logic [HN_W-1:0]        nx_reg  [HN_W+1];
    logic [HN_W-1:0]        ny_reg  [HN_W+1];
    logic [HD_W-1:0]        rx_reg  [HN_W+1];
    logic [HD_W-1:0]        ry_reg  [HN_W+1];

    logic [HN_W-1:0] nx_next [HN_W+1];
    logic [HN_W-1:0] ny_next [HN_W+1];
    logic [HD_W-1:0] rx_next [HN_W+1];
    logic [HD_W-1:0] ry_next [HN_W+1];

    always_comb
    begin
        logic [HD_W:0] shx, shy, dfx, dfy;
        nx_next[0] = HN_W'(width_reg) * HN_W'(ppem_reg) + HN_W'(em_eff);
        ny_next[0] = HN_W'(height_reg) * HN_W'(ppem_reg) + HN_W'(em_eff);
        rx_next[0] = '0;
        ry_next[0] = '0;
        for (int i = 1; i <= HN_W; i++)
        begin
            shx = {rx_reg[i-1], nx_reg[i-1][HN_W-1]};
            shy = {ry_reg[i-1], ny_reg[i-1][HN_W-1]};
            dfx = shx - {1'b0, em_twice};
            dfy = shy - {1'b0, em_twice};
            if (!dfx[HD_W])
            begin
                rx_next[i] = dfx[HD_W-1:0];
                nx_next[i] = {nx_reg[i-1][HN_W-2:0], 1'b1};
            end
            else
            begin
                rx_next[i] = shx[HD_W-1:0];
                nx_next[i] = {nx_reg[i-1][HN_W-2:0], 1'b0};
            end
            if (!dfy[HD_W])
            begin
                ry_next[i] = dfy[HD_W-1:0];
                ny_next[i] = {ny_reg[i-1][HN_W-2:0], 1'b1};
            end
            else
            begin
                ry_next[i] = shy[HD_W-1:0];
                ny_next[i] = {ny_reg[i-1][HN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= HN_W; i++)
                v1_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg[0] <= point_valid;
            for (int i = 1; i <= HN_W; i++)
                v1_reg[i] <= v1_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px1_reg[0] <= point_x;
            py1_reg[0] <= point_y;
            oc1_reg[0] <= point_flags[0];
            for (int i = 1; i <= HN_W; i++)
            begin
                px1_reg[i] <= px1_reg[i-1];
                py1_reg[i] <= py1_reg[i-1];
                oc1_reg[i] <= oc1_reg[i-1];
            end
            for (int i = 0; i <= HN_W; i++)
            begin
                nx_reg[i] <= nx_next[i];
                ny_reg[i] <= ny_next[i];
                rx_reg[i] <= rx_next[i];
                ry_reg[i] <= ry_next[i];
            end
        end
    end

    // multiply and sum stages
    logic                   vm1_reg, vm2_reg, vm3_reg, vm4_reg;
    logic                   ocm1_reg, ocm2_reg, ocm3_reg, ocm4_reg;
    logic signed [MP_W-1:0] mpx_reg, mpy_reg;
    logic [HN_W-1:0]        mhx_reg, mhy_reg;
    logic signed [D_W-1:0]  dx_reg, dy_reg;
    logic signed [P_W-1:0]  pcx_reg, psy_reg, pcy_reg, psx_reg;
    logic signed [A_W-1:0]  ax_reg, ay_reg;
    logic signed [MP_W-1:0] mpx_next, mpy_next;
    logic signed [A_W-1:0]  ax_next, ay_next;
    logic [A_W-1:0]         abx, aby;

    assign mpx_next = MP_W'(px1_reg[HN_W]) * $signed({1'b0, ppem_reg});
    assign mpy_next = MP_W'(py1_reg[HN_W]) * $signed({1'b0, ppem_reg});
    assign ax_next  = A_W'(pcx_reg) + A_W'(psy_reg);
    assign ay_next  = A_W'(pcy_reg) - A_W'(psx_reg);
    assign abx      = ax_reg[A_W-1] ? A_W'(-ax_reg) : A_W'(ax_reg);
    assign aby      = ay_reg[A_W-1] ? A_W'(-ay_reg) : A_W'(ay_reg);

    // final divider, index 0 is the magnitude stage
    logic            v2_reg  [M_W+1];
    logic            oc2_reg [M_W+1];
    logic            sx_reg  [M_W+1];
    logic            sy_reg  [M_W+1];
    logic [M_W-1:0]  qx_reg  [M_W+1];
    logic [M_W-1:0]  qy_reg  [M_W+1];
    logic [EM_W-1:0] qrx_reg [M_W+1];
    logic [EM_W-1:0] qry_reg [M_W+1];

    logic [M_W-1:0]  qx_next  [M_W+1];
    logic [M_W-1:0]  qy_next  [M_W+1];
    logic [EM_W-1:0] qrx_next [M_W+1];
    logic [EM_W-1:0] qry_next [M_W+1];

    always_comb
    begin
        logic [EM_W:0] shx, shy, dfx, dfy;
        qx_next[0]  = abx[A_W-1:SH];
        qy_next[0]  = aby[A_W-1:SH];
        qrx_next[0] = '0;
        qry_next[0] = '0;
        for (int i = 1; i <= M_W; i++)
        begin
            shx = {qrx_reg[i-1], qx_reg[i-1][M_W-1]};
            shy = {qry_reg[i-1], qy_reg[i-1][M_W-1]};
            dfx = shx - {1'b0, em_eff};
            dfy = shy - {1'b0, em_eff};
            if (!dfx[EM_W])
            begin
                qrx_next[i] = dfx[EM_W-1:0];
                qx_next[i]  = {qx_reg[i-1][M_W-2:0], 1'b1};
            end
            else
            begin
                qrx_next[i] = shx[EM_W-1:0];
                qx_next[i]  = {qx_reg[i-1][M_W-2:0], 1'b0};
            end
            if (!dfy[EM_W])
            begin
                qry_next[i] = dfy[EM_W-1:0];
                qy_next[i]  = {qy_reg[i-1][M_W-2:0], 1'b1};
            end
            else
            begin
                qry_next[i] = shy[EM_W-1:0];
                qy_next[i]  = {qy_reg[i-1][M_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
            vm3_reg <= 1'b0;
            vm4_reg <= 1'b0;
            for (int i = 0; i <= M_W; i++)
                v2_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vm1_reg   <= v1_reg[HN_W];
            vm2_reg   <= vm1_reg;
            vm3_reg   <= vm2_reg;
            vm4_reg   <= vm3_reg;
            v2_reg[0] <= vm4_reg;
            for (int i = 1; i <= M_W; i++)
                v2_reg[i] <= v2_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ocm1_reg <= oc1_reg[HN_W];
            mpx_reg  <= mpx_next;
            mpy_reg  <= mpy_next;
            mhx_reg  <= HN_W'(nx_reg[HN_W] * em_eff);
            mhy_reg  <= HN_W'(ny_reg[HN_W] * em_eff);

            ocm2_reg <= ocm1_reg;
            dx_reg   <= D_W'(mpx_reg) - D_W'($signed({1'b0, mhx_reg}));
            dy_reg   <= D_W'(mpy_reg) - D_W'($signed({1'b0, mhy_reg}));

            ocm3_reg <= ocm2_reg;
            pcx_reg  <= P_W'(c_reg) * P_W'(dx_reg);
            psy_reg  <= P_W'(s_reg) * P_W'(dy_reg);
            pcy_reg  <= P_W'(c_reg) * P_W'(dy_reg);
            psx_reg  <= P_W'(s_reg) * P_W'(dx_reg);

            ocm4_reg <= ocm3_reg;
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;

            oc2_reg[0] <= ocm4_reg;
            sx_reg[0]  <= ax_reg[A_W-1];
            sy_reg[0]  <= ay_reg[A_W-1];
            for (int i = 1; i <= M_W; i++)
            begin
                oc2_reg[i] <= oc2_reg[i-1];
                sx_reg[i]  <= sx_reg[i-1];
                sy_reg[i]  <= sy_reg[i-1];
            end
            for (int i = 0; i <= M_W; i++)
            begin
                qx_reg[i]  <= qx_next[i];
                qy_reg[i]  <= qy_next[i];
                qrx_reg[i] <= qrx_next[i];
                qry_reg[i] <= qry_next[i];
            end
        end
    end

    // sign, center offset, saturation
    logic signed [S_W-1:0]   offx, offy, sumx, sumy;
    logic signed [OUT_W-1:0] screen_x_next, screen_y_next;
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] screen_x_reg, screen_y_reg;
    logic                    on_curve_reg;

    assign offx = sx_reg[M_W] ? -$signed({2'b00, qx_reg[M_W]}) : $signed({2'b00, qx_reg[M_W]});
    assign offy = sy_reg[M_W] ? -$signed({2'b00, qy_reg[M_W]}) : $signed({2'b00, qy_reg[M_W]});
    assign sumx = CX_FIX + offx;
    assign sumy = CY_FIX + offy;

    always_comb
    begin
        if (sumx > SAT_MAX)
            screen_x_next = SAT_MAX[OUT_W-1:0];
        else if (sumx < SAT_MIN)
            screen_x_next = SAT_MIN[OUT_W-1:0];
        else
            screen_x_next = sumx[OUT_W-1:0];
        if (sumy > SAT_MAX)
            screen_y_next = SAT_MAX[OUT_W-1:0];
        else if (sumy < SAT_MIN)
            screen_y_next = SAT_MIN[OUT_W-1:0];
        else
            screen_y_next = sumy[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v2_reg[M_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            screen_x_reg <= screen_x_next;
            screen_y_reg <= screen_y_next;
            on_curve_reg <= oc2_reg[M_W];
        end
    end

    assign screen_valid = out_valid_reg;
    assign screen_x     = screen_x_reg;
    assign screen_y     = screen_y_reg;
    assign on_curve     = on_curve_reg;

endmodule

// ===== bench/gprs_checker.sv =====
module gprs_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [gprs_pkg::IDX_W-1:0]          cfg_index,
    input  logic [gprs_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                point_valid,
    input  logic                                point_stall,
    input  logic signed [gprs_pkg::PT_W-1:0]    point_x,
    input  logic signed [gprs_pkg::PT_W-1:0]    point_y,
    input  logic [gprs_pkg::FLAG_W-1:0]         point_flags,
    input  logic                                screen_valid,
    input  logic                                screen_stall,
    input  logic signed [gprs_pkg::OUT_W-1:0]   screen_x,
    input  logic signed [gprs_pkg::OUT_W-1:0]   screen_y,
    input  logic                                on_curve,
    output int                                  fail_count,
    output int                                  pending_count,
    output int                                  checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_W  = gprs_pkg::OUT_W;
    localparam int PT_W   = gprs_pkg::PT_W;
    localparam int FLAG_W = gprs_pkg::FLAG_W;
    localparam int ANG_W  = gprs_pkg::ANG_W;
    localparam int TFB    = gprs_pkg::TRIG_FRAC_BITS;
    localparam int SPB    = gprs_pkg::SUBPIXEL_BITS;

    typedef struct packed {
        logic signed [OUT_W-1:0] sx;
        logic signed [OUT_W-1:0] sy;
        logic                    oc;
    } screen_pos_t;

    logic [gprs_pkg::PPEM_W-1:0] ppem_q;
    logic [gprs_pkg::EM_W-1:0]   em_q;
    logic [ANG_W-1:0]            angle_q;
    logic [gprs_pkg::EXT_W-1:0]  width_q;
    logic [gprs_pkg::EXT_W-1:0]  height_q;

    screen_pos_t expected_positions[$];

    // Q30 Taylor series over the first quadrant, rounded to Q15
    function automatic longint round_q15(input longint q30);
        longint q;
        q = q30;
        if (q < 0)
            q = 0;
        if (q > (64'sd1 <<< 30))
            q = 64'sd1 <<< 30;
        return (q + (64'sd1 <<< (29 - TFB))) >>> (30 - TFB);
    endfunction

    function automatic void rotation_coefs(input logic [ANG_W-1:0] ang,
                                           output longint c, output longint s);
        longint unsigned x, x2, ct, st;
        longint csum, ssum, cc, ss;
        int k;
        x    = (64'(ang[7:0]) * 64'd3373259426) / 64'd512;
        x2   = (x * x) >> 30;
        csum = 64'sd1 <<< 30;
        ssum = longint'(x);
        ct   = 64'd1 << 30;
        st   = x;
        for (k = 1; k <= 12; k++)
        begin
            ct = ((ct * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            st = ((st * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
            begin
                csum -= longint'(ct);
                ssum -= longint'(st);
            end
            else
            begin
                csum += longint'(ct);
                ssum += longint'(st);
            end
        end
        cc = round_q15(csum);
        ss = round_q15(ssum);
        case (ang[9:8])
            gprs_pkg::QUAD_0: begin c = cc;  s = ss;  end
            gprs_pkg::QUAD_1: begin c = -ss; s = cc;  end
            gprs_pkg::QUAD_2: begin c = -cc; s = -ss; end
            default:          begin c = ss;  s = -cc; end
        endcase
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[OUT_W-1:0];
    endfunction

    function automatic screen_pos_t project_point(input logic signed [PT_W-1:0] px,
                                                  input logic signed [PT_W-1:0] py,
                                                  input logic [FLAG_W-1:0] fl);
        longint em, p, hx, hy, dx, dy, c, s, den;
        screen_pos_t r;
        em  = (em_q == 0) ? 64'sd1 : longint'(em_q);
        p   = longint'(ppem_q);
        hx  = (longint'(width_q) * p + em) / (2 * em);
        hy  = (longint'(height_q) * p + em) / (2 * em);
        dx  = longint'(px) * p - hx * em;
        dy  = longint'(py) * p - hy * em;
        rotation_coefs(angle_q, c, s);
        den = em * (64'sd1 <<< TFB);
        r.sx = clamp32(longint'(gprs_pkg::ORIGIN_X) * (64'sd1 <<< SPB)
                       + ((c * dx + s * dy) * (64'sd1 <<< SPB)) / den);
        r.sy = clamp32(longint'(gprs_pkg::ORIGIN_Y) * (64'sd1 <<< SPB)
                       + ((c * dy - s * dx) * (64'sd1 <<< SPB)) / den);
        r.oc = fl[0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        screen_pos_t e;
        if (!rst_n)
        begin
            ppem_q   <= gprs_pkg::PPEM_W'(449);
            em_q     <= gprs_pkg::EM_W'(2048);
            angle_q  <= '0;
            width_q  <= '0;
            height_q <= '0;
            expected_positions.delete();
            fail_count    <= 0;
            checked_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    gprs_pkg::REG_PPEM:   ppem_q   <= cfg_data[gprs_pkg::PPEM_W-1:0];
                    gprs_pkg::REG_EM:     em_q     <= cfg_data[gprs_pkg::EM_W-1:0];
                    gprs_pkg::REG_ANGLE:  angle_q  <= cfg_data[ANG_W-1:0];
                    gprs_pkg::REG_WIDTH:  width_q  <= cfg_data[gprs_pkg::EXT_W-1:0];
                    gprs_pkg::REG_HEIGHT: height_q <= cfg_data[gprs_pkg::EXT_W-1:0];
                    default: ;
                endcase
            end
            if (screen_valid && !screen_stall)
            begin
                checked_count <= checked_count + 1;
                if (expected_positions.size() == 0)
                begin
                    $error("screen word with nothing expected: x=%0d y=%0d",
                           screen_x, screen_y);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_positions.pop_front();
                    if (e.sx !== screen_x || e.sy !== screen_y || e.oc !== on_curve)
                        fail_count <= fail_count + 1;
                    if (e.sx !== screen_x)
                        $error("screen_x: expected %0d, got %0d", e.sx, screen_x);
                    if (e.sy !== screen_y)
                        $error("screen_y: expected %0d, got %0d", e.sy, screen_y);
                    if (e.oc !== on_curve)
                        $error("on_curve: expected %0b, got %0b", e.oc, on_curve);
                end
            end
            if (point_valid && !point_stall)
                expected_positions.push_back(project_point(point_x, point_y, point_flags));
            pending_count <= expected_positions.size();
        end
    end

endmodule

// ===== bench/tb_glyph_point_rotate_scale.sv =====
module tb_glyph_point_rotate_scale;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int CW    = gprs_pkg::CFG_W;
    localparam int IW    = gprs_pkg::IDX_W;
    localparam int PW    = gprs_pkg::PT_W;
    localparam int FW    = gprs_pkg::FLAG_W;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [IW-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;
    logic point_valid = 1'b0;
    logic point_stall;
    logic signed [PW-1:0] point_x = '0;
    logic signed [PW-1:0] point_y = '0;
    logic [FW-1:0] point_flags = '0;
    logic screen_valid;
    logic screen_stall = 1'b0;
    logic signed [gprs_pkg::OUT_W-1:0] screen_x;
    logic signed [gprs_pkg::OUT_W-1:0] screen_y;
    logic on_curve;

    int fail_count, pending_count, checked_count;
    int points_sent = 0;
    int setups_used = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    always #5 clk = ~clk;

    glyph_point_rotate_scale dut (.*);

    gprs_checker chk (.*);

    always @(posedge clk)
    begin
        if (rst_n && !((point_valid && !point_stall) || (screen_valid && !screen_stall)
                       || cfg_write_en))
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("** glyph_point_rotate_scale: FAILED **");
                $finish;
            end
        end
        else
            quiet_cycles <= 0;
    end

    // output side back-pressure
    initial
    begin
        int n;
        bit hold_done;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                screen_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                screen_stall = 1'b0;
            end
            else if (!calm && $urandom_range(0, 19) == 0)
            begin
                n = $urandom_range(1, 14);
                screen_stall = 1'b1;
                repeat (n) @(negedge clk);
                screen_stall = 1'b0;
            end
            else
                screen_stall = 1'b0;
        end
    end

    task automatic send_point(input logic [PW-1:0] x, input logic [PW-1:0] y,
                              input logic [FW-1:0] f);
        int n;
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 14);
            point_valid = 1'b0;
            repeat (n) @(negedge clk);
        end
        point_valid = 1'b1;
        point_x = x;
        point_y = y;
        point_flags = f;
        do
            @(posedge clk);
        while (point_stall);
        @(negedge clk);
        points_sent++;
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] val);
        cfg_write_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    task automatic drain();
        point_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic setup(input logic [CW-1:0] ppem, input logic [CW-1:0] em,
                         input logic [CW-1:0] ang, input logic [CW-1:0] w,
                         input logic [CW-1:0] h);
        drain();
        write_reg(gprs_pkg::REG_PPEM, ppem);
        write_reg(gprs_pkg::REG_EM, em);
        write_reg(gprs_pkg::REG_ANGLE, ang);
        write_reg(gprs_pkg::REG_WIDTH, w);
        write_reg(gprs_pkg::REG_HEIGHT, h);
        setups_used++;
    endtask

    task automatic corner_points();
        send_point(16'h8000, 16'h8000, 8'h00);
        send_point(16'h7FFF, 16'h7FFF, 8'hFF);
        send_point(16'h8000, 16'h7FFF, 8'h01);
        send_point(16'h7FFF, 16'h8000, 8'hFE);
        send_point(16'h0000, 16'h0000, 8'h55);
        send_point(16'hFFFF, 16'h0001, 8'hAA);
    endtask

    task automatic random_points(input int count);
        int k;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_point(16'($signed($urandom_range(0, 4000)) - 2000),
                           16'($signed($urandom_range(0, 4000)) - 2000), 8'($urandom));
            else
                send_point(16'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        int ph;
        logic [IW-1:0] idx;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        corner_points();
        drain();
        for (idx = IW'(gprs_pkg::REG_HEIGHT + 1); idx != '0; idx++)
            write_reg(idx, 16'hFFFF);
        corner_points();
        setup(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        corner_points();
        setup(CW'(1049), CW'(16), CW'(256), CW'(65535), CW'(0));
        corner_points();
        setup(CW'(0), CW'(16384), CW'(512), CW'(0), CW'(65535));
        send_point(16'h1234, 16'hEDCB, 8'h01);
        send_point(16'h7FFF, 16'h8000, 8'h00);

        for (ph = 0; ph < 10; ph++)
        begin
            setup(CW'($urandom_range(0, 1049)), CW'($urandom_range(16, 16384)),
                  CW'($urandom), CW'($urandom), CW'($urandom));
            if (ph == 3)
                hold_req = 1'b1;
            if (ph == 9)
                calm = 1'b1;
            random_points(ph == 3 ? 300 : 100);
        end
        setup(CW'($urandom), CW'($urandom), CW'(768), CW'($urandom), CW'($urandom));
        random_points(50);
        setup(CW'(449), CW'(2048), CW'(1023), CW'(1200), CW'(1400));
        random_points(50);

        drain();
        $display("Covered %0d points over %0d register setups, %0d results checked,",
                 points_sent, setups_used, checked_count);
        $display("including saturation, all quadrants, and a long output hold-off.");
        if (fail_count == 0)
            $display("** glyph_point_rotate_scale: PASSED **");
        else
            $display("** glyph_point_rotate_scale: FAILED **");
        $finish;
    end

endmodule
